[rtl/core/rtd_pkg.sv]
// ----------------------------------------------------------------------------
// rtd_pkg: shared types and constants for the PT100 linearizer
// Holds the resistance table, status codes and the stage-to-stage structs.
// ----------------------------------------------------------------------------
package rtd_pkg;

    localparam int TABLE_ENTRIES = 211;
    localparam int SEG_LAST      = TABLE_ENTRIES - 2;   // last segment lower index
    localparam int IDX_W         = 8;
    localparam int RES_W         = 16;
    localparam int TEMP_W        = 18;
    localparam int NUM_W         = 17;
    localparam int DEN_W         = 8;
    localparam int QUO_W         = 9;

    localparam logic [1:0] STATUS_IN    = 2'd0;
    localparam logic [1:0] STATUS_BELOW = 2'd1;
    localparam logic [1:0] STATUS_ABOVE = 2'd2;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -18'sd20000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sd85000;

    // resistance every 5 C from -200 C, in 0.01 ohm
    localparam logic [RES_W-1:0] RTD_ROM [0:TABLE_ENTRIES-1] = '{
        16'd1852, 16'd2068, 16'd2283, 16'd2497, 16'd2710, 16'd2922, 16'd3134, 16'd3344,
        16'd3554, 16'd3764, 16'd3972, 16'd4180, 16'd4388, 16'd4594, 16'd4800, 16'd5006,
        16'd5211, 16'd5415, 16'd5619, 16'd5823, 16'd6026, 16'd6228, 16'd6430, 16'd6631,
        16'd6833, 16'd7033, 16'd7233, 16'd7433, 16'd7633, 16'd7832, 16'd8031, 16'd8229,
        16'd8427, 16'd8625, 16'd8822, 16'd9019, 16'd9216, 16'd9412, 16'd9609, 16'd9804,
        16'd10000, 16'd10195, 16'd10390, 16'd10585, 16'd10779, 16'd10973, 16'd11167,
        16'd11361, 16'd11554, 16'd11747, 16'd11940, 16'd12132, 16'd12324, 16'd12516,
        16'd12708, 16'd12899, 16'd13090, 16'd13280, 16'd13471, 16'd13661, 16'd13851,
        16'd14040, 16'd14229, 16'd14418, 16'd14607, 16'd14795, 16'd14983, 16'd15171,
        16'd15358, 16'd15546, 16'd15733, 16'd15919, 16'd16105, 16'd16291, 16'd16477,
        16'd16663, 16'd16848, 16'd17033, 16'd17217, 16'd17402, 16'd17586, 16'd17769,
        16'd17953, 16'd18136, 16'd18319, 16'd18501, 16'd18684, 16'd18866, 16'd19047,
        16'd19229, 16'd19410, 16'd19591, 16'd19771, 16'd19951, 16'd20131, 16'd20311,
        16'd20490, 16'd20670, 16'd20848, 16'd21027, 16'd21205, 16'd21383, 16'd21561,
        16'd21738, 16'd21915, 16'd22092, 16'd22268, 16'd22445, 16'd22621, 16'd22796,
        16'd22972, 16'd23147, 16'd23321, 16'd23496, 16'd23670, 16'd23844, 16'd24018,
        16'd24191, 16'd24364, 16'd24537, 16'd24709, 16'd24881, 16'd25053, 16'd25225,
        16'd25396, 16'd25567, 16'd25738, 16'd25908, 16'd26078, 16'd26248, 16'd26418,
        16'd26587, 16'd26756, 16'd26925, 16'd27093, 16'd27261, 16'd27429, 16'd27597,
        16'd27764, 16'd27931, 16'd28098, 16'd28264, 16'd28430, 16'd28596, 16'd28762,
        16'd28927, 16'd29092, 16'd29256, 16'd29421, 16'd29585, 16'd29749, 16'd29912,
        16'd30075, 16'd30238, 16'd30401, 16'd30563, 16'd30725, 16'd30887, 16'd31049,
        16'd31210, 16'd31371, 16'd31531, 16'd31692, 16'd31852, 16'd32012, 16'd32171,
        16'd32330, 16'd32489, 16'd32648, 16'd32806, 16'd32964, 16'd33122, 16'd33279,
        16'd33436, 16'd33593, 16'd33750, 16'd33906, 16'd34062, 16'd34218, 16'd34373,
        16'd34528, 16'd34683, 16'd34838, 16'd34992, 16'd35146, 16'd35300, 16'd35453,
        16'd35606, 16'd35759, 16'd35912, 16'd36064, 16'd36216, 16'd36367, 16'd36519,
        16'd36670, 16'd36821, 16'd36971, 16'd37121, 16'd37271, 16'd37421, 16'd37570,
        16'd37719, 16'd37868, 16'd38017, 16'd38165, 16'd38313, 16'd38460, 16'd38608,
        16'd38755, 16'd38902, 16'd39048
    };

    localparam logic [RES_W-1:0] RES_LOW  = RTD_ROM[0];
    localparam logic [RES_W-1:0] RES_HIGH = RTD_ROM[TABLE_ENTRIES-1];

    function automatic logic [RES_W-1:0] rom_at(input logic [IDX_W-1:0] idx);
        logic [RES_W-1:0] v;
        v = '1;
        if (idx < IDX_W'(TABLE_ENTRIES)) begin
            v = RTD_ROM[idx];
        end
        return v;
    endfunction

    // search result: segment lower index and the sample
    typedef struct packed {
        logic              valid;
        logic [1:0]        status;
        logic [RES_W-1:0]  res;
        logic [IDX_W-1:0]  seg;
    } t_seg;

    // divider result
    typedef struct packed {
        logic                     valid;
        logic [1:0]               status;
        logic signed [TEMP_W-1:0] base;
        logic [QUO_W-1:0]         quo;
        logic                     rem_nz;
    } t_quo;

endpackage

[rtl/core/rtd_search.sv]
// ----------------------------------------------------------------------------
// rtd_search: pipelined binary search over the resistance table
// One index bit per stage, most significant first; finds the segment lower index.
// ----------------------------------------------------------------------------
module rtd_search (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [rtd_pkg::RES_W-1:0] i_res,
    output rtd_pkg::t_seg             o_seg
);
    import rtd_pkg::*;

    logic             r_valid [IDX_W];
    logic [1:0]       r_stat  [IDX_W];
    logic [RES_W-1:0] r_res   [IDX_W];
    logic [IDX_W-1:0] r_seg   [IDX_W];

    for (genvar s = 0; s < IDX_W; s++) begin : g_stage
        localparam logic [IDX_W-1:0] BIT = IDX_W'(1) << (IDX_W - 1 - s);

        logic             p_valid;
        logic [1:0]       p_stat;
        logic [RES_W-1:0] p_res;
        logic [IDX_W-1:0] p_seg;
        logic [IDX_W-1:0] cand;
        logic [IDX_W-1:0] n_seg;

        if (s == 0) begin : g_first
            always_comb begin
                p_valid = i_valid;
                p_res   = i_res;
                p_seg   = '0;
                p_stat  = STATUS_IN;
                if (i_res < RES_LOW) begin
                    p_stat = STATUS_BELOW;
                end else if (i_res > RES_HIGH) begin
                    p_stat = STATUS_ABOVE;
                end
            end
        end else begin : g_next
            assign p_valid = r_valid[s-1];
            assign p_stat  = r_stat[s-1];
            assign p_res   = r_res[s-1];
            assign p_seg   = r_seg[s-1];
        end

        assign cand = p_seg | BIT;

        // advance to the candidate when it stays in range and its entry is not above
        always_comb begin
            n_seg = p_seg;
            if (cand <= IDX_W'(SEG_LAST) && rom_at(cand) <= p_res) begin
                n_seg = cand;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stat[s] <= p_stat;
                r_res[s]  <= p_res;
                r_seg[s]  <= n_seg;
            end
        end
    end

    assign o_seg.valid  = r_valid[IDX_W-1];
    assign o_seg.status = r_stat[IDX_W-1];
    assign o_seg.res    = r_res[IDX_W-1];
    assign o_seg.seg    = r_seg[IDX_W-1];

endmodule

[rtl/core/rtd_div.sv]
// ----------------------------------------------------------------------------
// rtd_div: segment setup and pipelined restoring divider
// Forms (R - lo) * 500 over (hi - lo), then three quotient bits per stage.
// ----------------------------------------------------------------------------
module rtd_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  rtd_pkg::t_seg i_seg,
    output rtd_pkg::t_quo o_quo
);
    import rtd_pkg::*;

    localparam int STAGES = 3;
    localparam int STEPS  = QUO_W / STAGES;

    // setup stage
    logic                     r_valid;
    logic [1:0]               r_stat;
    logic signed [TEMP_W-1:0] r_base;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;

    logic [RES_W-1:0]  lo;
    logic [RES_W-1:0]  hi;
    logic [RES_W-1:0]  diff;
    logic [IDX_W-1:0]  seg_up;

    assign seg_up = i_seg.seg + IDX_W'(1);
    assign lo     = rom_at(i_seg.seg);
    assign hi     = rom_at(seg_up);
    // out-of-range samples carry a don't-care difference; clamp it to zero
    assign diff   = (i_seg.status == STATUS_IN) ? (i_seg.res - lo) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stat <= i_seg.status;
            r_num  <= NUM_W'(diff[DEN_W:0]) * NUM_W'(500);
            r_den  <= DEN_W'(hi - lo);
            r_base <= $signed({1'b0, i_seg.seg, 9'd0}) - $signed({1'b0, i_seg.seg, 3'd0})
                      - $signed({1'b0, i_seg.seg, 2'd0}) - 18'sd20000;
        end
    end

    // division stages
    logic                     d_valid [STAGES];
    logic [1:0]               d_stat  [STAGES];
    logic signed [TEMP_W-1:0] d_base  [STAGES];
    logic [NUM_W-1:0]         d_rem   [STAGES];
    logic [DEN_W-1:0]         d_den   [STAGES];
    logic [QUO_W-1:0]         d_quo   [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_dstage
        logic                     p_valid;
        logic [1:0]               p_stat;
        logic signed [TEMP_W-1:0] p_base;
        logic [NUM_W-1:0]         p_rem;
        logic [DEN_W-1:0]         p_den;
        logic [QUO_W-1:0]         p_quo;
        logic [NUM_W-1:0]         n_rem;
        logic [QUO_W-1:0]         n_quo;

        if (k == 0) begin : g_first
            assign p_valid = r_valid;
            assign p_stat  = r_stat;
            assign p_base  = r_base;
            assign p_rem   = r_num;
            assign p_den   = r_den;
            assign p_quo   = '0;
        end else begin : g_next
            assign p_valid = d_valid[k-1];
            assign p_stat  = d_stat[k-1];
            assign p_base  = d_base[k-1];
            assign p_rem   = d_rem[k-1];
            assign p_den   = d_den[k-1];
            assign p_quo   = d_quo[k-1];
        end

        always_comb begin
            logic [NUM_W-1:0] sub;
            n_rem = p_rem;
            n_quo = p_quo;
            for (int j = 0; j < STEPS; j++) begin
                sub = NUM_W'(p_den) << (QUO_W - 1 - k * STEPS - j);
                if (n_rem >= sub) begin
                    n_rem = n_rem - sub;
                    n_quo[QUO_W - 1 - k * STEPS - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                d_valid[k] <= 1'b0;
            end else if (i_en) begin
                d_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                d_stat[k] <= p_stat;
                d_base[k] <= p_base;
                d_rem[k]  <= n_rem;
                d_den[k]  <= p_den;
                d_quo[k]  <= n_quo;
            end
        end
    end

    assign o_quo.valid  = d_valid[STAGES-1];
    assign o_quo.status = d_stat[STAGES-1];
    assign o_quo.base   = d_base[STAGES-1];
    assign o_quo.quo    = d_quo[STAGES-1];
    assign o_quo.rem_nz = (d_rem[STAGES-1] != '0);

endmodule

[rtl/core/rtd_table_linearizer.sv]
// ----------------------------------------------------------------------------
// rtd_table_linearizer: PT100 resistance to temperature
// Table search plus linear interpolation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_resistance_centiohm in 0.01 ohm.
//   Output channel: o_valid / i_stall with o_temperature_centideg (0.01 C,
//   truncated toward zero) and o_range_status (0 in table, 1 below, 2 above).
//   Every sample gives exactly one result, in order.
// Pipeline: from input transfer to o_valid, eight search stages
//   (one table index bit each), one segment setup stage, three divider
//   stages (three quotient bits each) and the output register.
// Throughput: one sample per cycle unless stalled; the rate is set by
//   the per-stage table reads and the three-step divider slices.
// Stall: the whole pipeline advances together. While a result waits in
//   the output register and i_stall is high, every stage holds and o_stall
//   goes high, so nothing is dropped or repeated.
// Reset: synchronous, active low; clears all valid bits. The block keeps
//   no state between samples.
// ----------------------------------------------------------------------------
module rtd_table_linearizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [rtd_pkg::RES_W-1:0]         i_resistance_centiohm,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [rtd_pkg::TEMP_W-1:0] o_temperature_centideg,
    output logic [1:0]                        o_range_status
);
    import rtd_pkg::*;

    t_seg seg;
    t_quo quo;
    logic en;

    logic                     r_valid;
    logic signed [TEMP_W-1:0] r_temp;
    logic [1:0]               r_stat;
    logic signed [TEMP_W-1:0] n_temp;

    // hold every stage while the output waits
    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    rtd_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_res   (i_resistance_centiohm),
        .o_seg   (seg)
    );

    rtd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_seg   (seg),
        .o_quo   (quo)
    );

    // base plus quotient; below zero a nonzero remainder rounds toward zero
    always_comb begin
        n_temp = quo.base + $signed({{(TEMP_W-QUO_W){1'b0}}, quo.quo});
        if (quo.base < 0 && quo.rem_nz) begin
            n_temp = n_temp + 18'sd1;
        end
        if (quo.status == STATUS_BELOW) begin
            n_temp = TEMP_MIN;
        end else if (quo.status == STATUS_ABOVE) begin
            n_temp = TEMP_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= quo.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp <= n_temp;
            r_stat <= quo.status;
        end
    end

    assign o_valid                = r_valid;
    assign o_temperature_centideg = r_temp;
    assign o_range_status         = r_stat;

`ifndef SYNTH
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_centideg >= TEMP_MIN && o_temperature_centideg <= TEMP_MAX))
        else $error("temperature out of table range");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_range_status != 2'd3))
        else $error("invalid range status");

    a_clamp_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_status == STATUS_BELOW) |-> (o_temperature_centideg == TEMP_MIN))
        else $error("below-range sample not clamped");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (o_valid && $stable(o_temperature_centideg) && $stable(o_range_status)))
        else $error("pipeline moved during stall");
`endif

endmodule

[tb/rtd_checker.sv]
// ----------------------------------------------------------------------------
// rtd_checker: scoreboard for the PT100 linearizer
// Watches both channels, predicts each temperature and compares in order.
// ----------------------------------------------------------------------------
module rtd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic [rtd_pkg::RES_W-1:0]         i_resistance_centiohm,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic signed [rtd_pkg::TEMP_W-1:0] o_temperature_centideg,
    input  logic [1:0]                        o_range_status,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rtd_pkg::*;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [1:0]               status;
    } t_reading;

    t_reading pending_readings[$];

    // expected temperature for one sample
    function automatic t_reading convert_sample(input logic [RES_W-1:0] r);
        t_reading res;
        int bot, top, mid, lo, hi, num, den, q, rem, base, t;
        bit hit;
        res.status = STATUS_IN;
        hit = 0;
        t = 0;
        if (r < RES_LOW) begin
            res.temp = TEMP_MIN;
            res.status = STATUS_BELOW;
        end else if (r > RES_HIGH) begin
            res.temp = TEMP_MAX;
            res.status = STATUS_ABOVE;
        end else begin
            bot = 0;
            top = TABLE_ENTRIES - 1;
            mid = (TABLE_ENTRIES - 1) / 2;
            while (top - bot != 1 && !hit) begin
                if (r < RTD_ROM[mid]) top = mid;
                else if (r > RTD_ROM[mid]) bot = mid;
                else begin
                    hit = 1;
                    t = mid * 500 - 20000;
                end
                mid = (top + bot) / 2;
            end
            if (!hit) begin
                lo = RTD_ROM[bot];
                hi = RTD_ROM[top];
                num = (int'(r) - lo) * 500;
                den = hi - lo;
                base = bot * 500 - 20000;
                q = num / den;
                rem = num % den;
                t = base + q;
                if (base < 0 && rem != 0) t = t + 1;
            end
            res.temp = TEMP_W'(t);
        end
        return res;
    endfunction

    assign o_pending = pending_readings.size();

    always @(posedge i_clk) begin
        t_reading exp_r;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_readings.push_back(convert_sample(i_resistance_centiohm));
            end
            if (o_valid && !i_stall) begin
                if (pending_readings.size() == 0) begin
                    $error("unexpected result transfer");
                    errs++;
                end else begin
                    exp_r = pending_readings.pop_front();
                    if (exp_r.temp !== o_temperature_centideg) begin
                        $error("temperature_centideg expected %0d actual %0d",
                               exp_r.temp, o_temperature_centideg);
                        errs++;
                    end
                    if (exp_r.status !== o_range_status) begin
                        $error("range_status expected %0d actual %0d",
                               exp_r.status, o_range_status);
                        errs++;
                    end
                end
            end
            if (errs != 0) begin
                o_fail_count <= o_fail_count + errs;
            end
        end
    end
endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top for the PT100 linearizer
// Drives directed and random resistance samples in bursts against a
// stalling receiver; the checker compares every temperature in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rtd_pkg::*;

    localparam int LATENCY     = 13;
    localparam int CYCLE_LIMIT = 200000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [RES_W-1:0]         i_resistance_centiohm;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [TEMP_W-1:0] o_temperature_centideg;
    logic [1:0]               o_range_status;
    int                       fail_count;
    int                       pending;
    int                       cycle_count = 0;
    bit                       stall_enable;

    rtd_table_linearizer DUT (.*);

    rtd_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_resistance_centiohm,
        .o_valid, .i_stall, .o_temperature_centideg, .o_range_status,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // watchdog: end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern: calm stretches and busy stretches
    always @(negedge i_clk) begin
        if (!stall_enable) i_stall <= 1'b0;
        else if (cycle_count[9:7] == 3'd0) i_stall <= 1'b0;
        else if (cycle_count[9:7] == 3'd5) i_stall <= ($urandom_range(0, 9) < 8);
        else i_stall <= ($urandom_range(0, 3) == 0);
    end

    // hold the sample until the transfer happens; valid is left high
    task automatic send_sample(input logic [RES_W-1:0] r);
        i_valid <= 1'b1;
        i_resistance_centiohm <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // pick a sample: mostly inside the table, some table hits and outliers
    function automatic logic [RES_W-1:0] pick_sample();
        int sel;
        int idx;
        sel = $urandom_range(0, 19);
        idx = $urandom_range(0, TABLE_ENTRIES - 1);
        if (sel < 12) return RES_W'($urandom_range(RES_LOW, RES_HIGH));
        if (sel < 14) return RTD_ROM[idx];
        if (sel < 15) return RES_W'(RTD_ROM[idx] + RES_W'($urandom_range(0, 2)) - 1);
        if (sel < 17) return RES_W'($urandom_range(0, RES_LOW - 1));
        if (sel < 19) return RES_W'($urandom_range(RES_HIGH + 1, 65535));
        return RES_W'($urandom());
    endfunction

    initial begin
        int gap;
        int burst;
        int sent;
        int wait_count;
        logic [RES_W-1:0] directed[$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_resistance_centiohm = '0;
        stall_enable = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        stall_enable = 1'b1;

        // extremes, endpoints, table hits and the first segment
        directed = '{16'd0, 16'd1, 16'd1851, 16'd1852, 16'd1853, 16'd2067, 16'd2068,
                     16'd10000, 16'd10001, 16'd9999, 16'd20131, 16'd39047, 16'd39048,
                     16'd39049, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
                     16'd38902, 16'd38903, 16'd5000};
        foreach (directed[k]) send_sample(directed[k]);

        sent = 0;
        while (sent < 2000) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_sample(pick_sample());
                sent++;
            end
            i_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b0;

        // drain, then allow for the pipeline depth
        wait_count = 0;
        while (pending != 0 && wait_count < 10000) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (LATENCY * 3) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
